>>> sv/lmcs_pkg.sv
// shared types, constants and the column stream builder of the led matrix serializer
package lmcs_pkg;

   localparam int COLUMNS     = 10;
   localparam int FRAME_WORDS = 5;
   localparam int STREAM_BITS = 24;

   localparam int COL_W  = 4;   // columns 0..9 plus the blanking pass
   localparam int BIT_W  = 5;   // bit position 0..23
   localparam int IDX_W  = 3;   // frame word index
   localparam int WORD_W = 32;
   localparam int GAP_W  = 24;

   localparam logic [WORD_W-1:0] EVEN_BITS = 32'h5555_5555;
   localparam logic [WORD_W-1:0] STEP0     = 32'd4281684;
   localparam logic [WORD_W-1:0] STEP1     = 32'd43688;
   localparam logic [WORD_W-1:0] STEP2     = 32'd1360;
   localparam logic [WORD_W-1:0] STEP3     = 32'd160;

   // register indexes of the csr port
   localparam logic REG_COLUMN_GAP = 1'b0;
   localparam logic REG_FRAME_GAP  = 1'b1;

   // input kinds carried on tuser
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   typedef struct packed {
      logic [GAP_W-1:0] column_gap;
      logic [GAP_W-1:0] frame_gap;
   } gap_cfg_type;

   typedef struct packed {
      logic latch;
      logic shift_data;
      logic shift_clock;
   } pins_type;

   typedef enum logic [3:0] {
      PH_LOW   = 4'b0001,
      PH_HIGH  = 4'b0010,
      PH_LATCH = 4'b0100,
      PH_GAP   = 4'b1000
   } phase_type;

   function automatic logic [STREAM_BITS-1:0] select_mask(input logic [COL_W-1:0] col);
      logic [STREAM_BITS-1:0] m;
      case (col)
         4'd0:    m = 24'd732576;
         4'd1:    m = 24'd4402592;
         4'd2:    m = 24'd4795808;
         4'd3:    m = 24'd4861344;
         4'd4:    m = 24'd4918688;
         4'd5:    m = 24'd4924832;
         4'd6:    m = 24'd4925856;
         4'd7:    m = 24'd4926624;
         4'd8:    m = 24'd4926752;
         4'd9:    m = 24'd4926848;
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [WORD_W-1:0] squeeze(input logic [WORD_W-1:0] v,
                                                 input logic [WORD_W-1:0] m);
      return (v & ~m) | ((v & m) >> 1);
   endfunction

   // word is the raw frame word picked for this column
   function automatic logic [STREAM_BITS-1:0] build_stream(input logic [WORD_W-1:0] word,
                                                         input logic [COL_W-1:0]  col);
      logic [WORD_W-1:0] v;
      if (col >= COL_W'(COLUMNS)) begin
         return '0;
      end
      v = (col < COL_W'(FRAME_WORDS)) ? word : (word >> 1);
      v = v & EVEN_BITS;
      v = squeeze(v, STEP0);
      v = squeeze(v, STEP1);
      v = squeeze(v, STEP2);
      v = squeeze(v, STEP3);
      return v[STREAM_BITS-1:0] | select_mask(col);
   endfunction

endpackage

>>> sv/lmcs_csr.sv
// csr block holding the column and frame gap registers
module lmcs_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output lmcs_pkg::gap_cfg_type      gap_cfg
);

   logic [lmcs_pkg::GAP_W-1:0] column_gap_ff, column_gap_in;
   logic [lmcs_pkg::GAP_W-1:0] frame_gap_ff, frame_gap_in;
   logic                       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      column_gap_in = column_gap_ff;
      frame_gap_in  = frame_gap_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            lmcs_pkg::REG_COLUMN_GAP: column_gap_in = csr_pwdata[lmcs_pkg::GAP_W-1:0];
            lmcs_pkg::REG_FRAME_GAP:  frame_gap_in  = csr_pwdata[lmcs_pkg::GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_gap_ff <= 24'd1000;
         frame_gap_ff  <= 24'd10000;
      end else begin
         column_gap_ff <= column_gap_in;
         frame_gap_ff  <= frame_gap_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         lmcs_pkg::REG_COLUMN_GAP: csr_prdata = {8'd0, column_gap_ff};
         lmcs_pkg::REG_FRAME_GAP:  csr_prdata = {8'd0, frame_gap_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   assign gap_cfg.column_gap = column_gap_ff;
   assign gap_cfg.frame_gap  = frame_gap_ff;

endmodule

>>> sv/lmcs_frame_store.sv
// five-word frame store with one write port and one column-selected read
module lmcs_frame_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [lmcs_pkg::IDX_W-1:0]    wr_idx,
   input  logic [lmcs_pkg::WORD_W-1:0]   wr_data,
   input  logic [lmcs_pkg::COL_W-1:0]    col,
   output logic [lmcs_pkg::WORD_W-1:0]   rd_word
);

   logic [lmcs_pkg::WORD_W-1:0] store_ff [lmcs_pkg::FRAME_WORDS];
   logic [lmcs_pkg::IDX_W-1:0]  rd_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lmcs_pkg::FRAME_WORDS; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_en && (wr_idx < lmcs_pkg::IDX_W'(lmcs_pkg::FRAME_WORDS))) begin
         store_ff[wr_idx] <= wr_data;
      end
   end

   // left half walks the words backwards, right half forwards
   always_comb begin
      if (col < lmcs_pkg::COL_W'(lmcs_pkg::FRAME_WORDS)) begin
         rd_idx = lmcs_pkg::IDX_W'(lmcs_pkg::COL_W'(lmcs_pkg::FRAME_WORDS - 1) - col);
      end else begin
         rd_idx = lmcs_pkg::IDX_W'(col - lmcs_pkg::COL_W'(lmcs_pkg::FRAME_WORDS));
      end
   end

   assign rd_word = (rd_idx < lmcs_pkg::IDX_W'(lmcs_pkg::FRAME_WORDS)) ? store_ff[rd_idx] : '0;

endmodule

>>> sv/lmcs_scan.sv
// scan sequencer: shift, latch and gap phases for every column and the blanking pass
module lmcs_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick,
   input  lmcs_pkg::gap_cfg_type         gap_cfg,
   input  logic [lmcs_pkg::WORD_W-1:0]   frame_word,
   output logic [lmcs_pkg::COL_W-1:0]    col,
   output lmcs_pkg::pins_type            pins
);

   lmcs_pkg::phase_type                   phase_ff, phase_in;
   logic [lmcs_pkg::COL_W-1:0]            col_ff, col_in;
   logic [lmcs_pkg::BIT_W-1:0]            bit_ff, bit_in;
   logic [lmcs_pkg::GAP_W-1:0]            gap_ff, gap_in;
   logic [lmcs_pkg::STREAM_BITS-1:0]      stream_ff, stream_in;
   logic [lmcs_pkg::STREAM_BITS-1:0]      stream_now;
   logic [lmcs_pkg::GAP_W-1:0]            gap_load;
   logic [lmcs_pkg::COL_W-1:0]            col_next;

   assign col = col_ff;

   // the stream is rebuilt on the first shift of every pass
   assign stream_now = (bit_ff == '0) ? lmcs_pkg::build_stream(frame_word, col_ff) : stream_ff;
   assign gap_load   = (col_ff < lmcs_pkg::COL_W'(lmcs_pkg::COLUMNS)) ?
                       gap_cfg.column_gap : gap_cfg.frame_gap;
   assign col_next   = (col_ff >= lmcs_pkg::COL_W'(lmcs_pkg::COLUMNS)) ?
                       '0 : col_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      col_in    = col_ff;
      bit_in    = bit_ff;
      gap_in    = gap_ff;
      stream_in = stream_ff;
      pins      = '{latch: 1'b1, shift_data: stream_ff[lmcs_pkg::STREAM_BITS-1],
                    shift_clock: 1'b1};
      unique case (phase_ff)
         lmcs_pkg::PH_LOW: begin
            pins      = '{latch: 1'b0, shift_data: stream_now[bit_ff], shift_clock: 1'b0};
            stream_in = stream_now;
            phase_in  = lmcs_pkg::PH_HIGH;
         end
         lmcs_pkg::PH_HIGH: begin
            pins = '{latch: 1'b0, shift_data: stream_ff[bit_ff], shift_clock: 1'b1};
            if (bit_ff == lmcs_pkg::BIT_W'(lmcs_pkg::STREAM_BITS - 1)) begin
               bit_in   = '0;
               phase_in = lmcs_pkg::PH_LATCH;
            end else begin
               bit_in   = bit_ff + 1'b1;
               phase_in = lmcs_pkg::PH_LOW;
            end
         end
         lmcs_pkg::PH_LATCH: begin
            if (gap_load == '0) begin
               col_in   = col_next;
               phase_in = lmcs_pkg::PH_LOW;
            end else begin
               gap_in   = gap_load;
               phase_in = lmcs_pkg::PH_GAP;
            end
         end
         lmcs_pkg::PH_GAP: begin
            if (gap_ff <= lmcs_pkg::GAP_W'(1)) begin
               gap_in   = '0;
               col_in   = col_next;
               phase_in = lmcs_pkg::PH_LOW;
            end else begin
               gap_in = gap_ff - 1'b1;
            end
         end
         default: begin
            phase_in = lmcs_pkg::PH_LOW;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lmcs_pkg::PH_LOW;
         col_ff    <= '0;
         bit_ff    <= '0;
         gap_ff    <= '0;
         stream_ff <= '0;
      end else if (tick) begin
         phase_ff  <= phase_in;
         col_ff    <= col_in;
         bit_ff    <= bit_in;
         gap_ff    <= gap_in;
         stream_ff <= stream_in;
      end
   end

endmodule

>>> sv/lmcs_out_buf.sv
// two-entry output buffer (result register plus skid register)
module lmcs_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lmcs_pkg::pins_type  push_pins,
   output logic                can_accept,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata
);

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   lmcs_pkg::pins_type main_ff, main_in;
   lmcs_pkg::pins_type skid_ff, skid_in;
   logic               take;

   assign can_accept = ~skid_valid_ff;
   assign take       = main_valid_ff & rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_pins;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = push_pins;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_pins;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {5'd0, main_ff};

endmodule

>>> sv/led_matrix_column_scan_serializer_top.sv
// top level of the led matrix column scan serializer
// Drives the shift clock, serial data and latch pins of a 24-bit shift-register
// chain that scans an LED matrix. Each input word is either a frame write
// (tuser low: replaces one of five 32-bit frame words, no response) or a scan
// tick (tuser high: advances the pins by one step and returns one response word
// with the new pin levels). Per column, 24 bits go out LSB first as clock-low /
// clock-high tick pairs with the latch low, then one latch tick, then
// column_gap_ticks idle ticks; after ten columns a blanking pass shifts 24 zeros,
// latches and waits frame_gap_ticks. The column stream is compacted from the
// frame word on the first tick of each pass, so frame writes show from the next
// column on. Throughput is one input word per clock while req_tready is high; a
// tick's response is registered in the output buffer's result register, or in
// its skid register while the result register is held, and the pin levels come
// straight from the scan sequencer's logic. A two-entry output buffer keeps
// req_tready high while one response waits; req_tready drops only when two are
// pending. Reset restores the gap registers to 1000 and 10000 and clears the
// frame store and scan state at once; there is no clearing pass. Gap registers
// sit at csr byte address 0 (column gap) and 4 (frame gap), 24 bits each.
module led_matrix_column_scan_serializer_top (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] word_index, [34:3] word_data, rest zero
   input  logic        req_tuser,   // [0] action: 0 frame write, 1 scan tick
   // response words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] shift_clock, [1] shift_data, [2] latch, rest zero
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lmcs_pkg::gap_cfg_type              gap_cfg;
   lmcs_pkg::pins_type                 pins;
   logic                               accept;
   logic                               tick;
   logic                               write;
   logic                               can_accept;
   logic [lmcs_pkg::COL_W-1:0]         col;
   logic [lmcs_pkg::WORD_W-1:0]        frame_word;

   assign req_tready = can_accept;
   assign accept     = req_tvalid & req_tready;
   assign tick       = accept & (req_tuser == lmcs_pkg::ACT_TICK);
   assign write      = accept & (req_tuser == lmcs_pkg::ACT_WRITE);

   // gap registers
   lmcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gap_cfg     (gap_cfg)
   );

   // frame words, read by the column currently being scanned
   lmcs_frame_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (write),
      .wr_idx  (req_tdata[2:0]),
      .wr_data (req_tdata[34:3]),
      .col     (col),
      .rd_word (frame_word)
   );

   // pin sequencer, steps once per accepted tick
   lmcs_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .gap_cfg    (gap_cfg),
      .frame_word (frame_word),
      .col        (col),
      .pins       (pins)
   );

   // response register plus skid entry
   lmcs_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (tick),
      .push_pins  (pins),
      .can_accept (can_accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> sv/lmcs_checker.sv
// port-level checker for the led matrix serializer and its bind
module lmcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_pready
);

   // a held response keeps its pins
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // input side only backs up once a response is waiting
   a_ready_buffered: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no response pending");

   // latch only ever shows with the shift clock high
   a_latch_clock: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[0])
      else $error("latch high with shift clock low");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:3] == 5'd0)
      else $error("response padding not zero");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr ready dropped");

endmodule

bind led_matrix_column_scan_serializer_top lmcs_checker u_lmcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

>>> test/tb_top.sv
// self-checking testbench of the led matrix column scan serializer: stream stimulus, pin prediction
`timescale 1ns / 100ps

module tb_top;

   // run limit, far above the slowest correct run (about 1400 words at 71% stall)
   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_LIMIT   = 10;
   localparam int HOLD_OFF_TICKS = 300;
   localparam int DRAIN_CYCLES   = 4;
   localparam logic [lmcs_pkg::GAP_W-1:0] GAP_MAX = '1;

   // pixel compaction: even-bit mask, then four squeeze steps, first step in [0]
   localparam logic [lmcs_pkg::WORD_W-1:0] PIXEL_MASK = 32'h5555_5555;
   localparam logic [3:0][lmcs_pkg::WORD_W-1:0] PACK_STEP =
      {32'd160, 32'd1360, 32'd43688, 32'd4281684};
   // column select pattern ORed over the pixels, column 0 in [0]
   localparam logic [9:0][lmcs_pkg::STREAM_BITS-1:0] COLUMN_SELECT = {
      24'd4926848, 24'd4926752, 24'd4926624, 24'd4925856, 24'd4924832,
      24'd4918688, 24'd4861344, 24'd4795808, 24'd4402592, 24'd732576};

   typedef enum logic [3:0] {
      SCAN_LOW   = 4'b0001,
      SCAN_HIGH  = 4'b0010,
      SCAN_LATCH = 4'b0100,
      SCAN_GAP   = 4'b1000
   } scan_phase_type;

   typedef struct packed {
      logic               act;
      logic [2:0]         idx;
      logic [31:0]        dat;
      logic               typed;
      lmcs_pkg::pins_type pins;
   } opening_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [2:0] word_index, [34:3] word_data, rest zero
   logic        req_tuser;   // [0] action: 0 frame write, 1 scan tick
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] shift_clock, [1] shift_data, [2] latch, rest zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   led_matrix_column_scan_serializer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted scan state, a private copy kept in step with accepted words
   logic [lmcs_pkg::WORD_W-1:0]      frame_words [lmcs_pkg::FRAME_WORDS];
   logic [lmcs_pkg::COL_W-1:0]       scan_col;
   logic [lmcs_pkg::BIT_W-1:0]       scan_bit;
   scan_phase_type                   scan_phase;
   logic [lmcs_pkg::GAP_W-1:0]       gap_left;
   logic [lmcs_pkg::STREAM_BITS-1:0] stream_bits;
   logic [lmcs_pkg::GAP_W-1:0]       column_gap;
   logic [lmcs_pkg::GAP_W-1:0]       frame_gap;

   lmcs_pkg::pins_type expected_pins [$];
   opening_row_type    opening_rows [23];

   int fail_count;
   int result_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   bit backpressure_due;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("led_matrix_column_scan_serializer_top verification failed");
         $finish;
      end
   end

   task automatic flag_error(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%s", what);
      end
   endtask

   // 24-bit stream of one pass; the blanking pass is all zeros
   function automatic logic [lmcs_pkg::STREAM_BITS-1:0] column_pattern(
      input logic [lmcs_pkg::COL_W-1:0] col);
      logic [lmcs_pkg::WORD_W-1:0] v;
      if (col >= lmcs_pkg::COL_W'(lmcs_pkg::COLUMNS)) begin
         return '0;
      end
      // left half reads words 4..0 even bits, right half words 0..4 odd bits
      if (col < lmcs_pkg::COL_W'(lmcs_pkg::FRAME_WORDS)) begin
         v = frame_words[lmcs_pkg::FRAME_WORDS - 1 - int'(col)];
      end else begin
         v = frame_words[int'(col) - lmcs_pkg::FRAME_WORDS] >> 1;
      end
      v = v & PIXEL_MASK;
      for (int s = 0; s < 4; s++) begin
         v = (v & ~PACK_STEP[s]) | ((v & PACK_STEP[s]) >> 1);
      end
      return v[lmcs_pkg::STREAM_BITS-1:0] | COLUMN_SELECT[col];
   endfunction

   function automatic void start_next_pass();
      scan_col   = (scan_col >= lmcs_pkg::COL_W'(lmcs_pkg::COLUMNS)) ? '0 : scan_col + 1'b1;
      scan_bit   = '0;
      scan_phase = SCAN_LOW;
      gap_left   = '0;
   endfunction

   // advances the predicted scan by one tick and returns the pin levels it shows
   function automatic lmcs_pkg::pins_type scan_tick();
      lmcs_pkg::pins_type         p;
      logic [lmcs_pkg::GAP_W-1:0] gap;
      case (scan_phase)
         SCAN_LOW: begin
            // stream is rebuilt at the first bit, so writes show from the next pass
            if (scan_bit == '0) begin
               stream_bits = column_pattern(scan_col);
            end
            p = {1'b0, stream_bits[scan_bit], 1'b0};
            scan_phase = SCAN_HIGH;
         end
         SCAN_HIGH: begin
            p = {1'b0, stream_bits[scan_bit], 1'b1};
            if (scan_bit == lmcs_pkg::BIT_W'(lmcs_pkg::STREAM_BITS - 1)) begin
               scan_bit   = '0;
               scan_phase = SCAN_LATCH;
            end else begin
               scan_bit   = scan_bit + 1'b1;
               scan_phase = SCAN_LOW;
            end
         end
         SCAN_LATCH: begin
            p   = {1'b1, stream_bits[lmcs_pkg::STREAM_BITS-1], 1'b1};
            gap = (scan_col < lmcs_pkg::COL_W'(lmcs_pkg::COLUMNS)) ? column_gap : frame_gap;
            // zero gap goes straight on to the next pass
            if (gap == '0) begin
               start_next_pass();
            end else begin
               gap_left   = gap;
               scan_phase = SCAN_GAP;
            end
         end
         default: begin
            p = {1'b1, stream_bits[lmcs_pkg::STREAM_BITS-1], 1'b1};
            if (gap_left != '0) begin
               gap_left = gap_left - 1'b1;
            end
            if (gap_left == '0) begin
               start_next_pass();
            end
         end
      endcase
      return p;
   endfunction

   // offers one word, waits for its acceptance and records what it should cause;
   // leaves req_tvalid high so back-to-back words need no second assignment
   task automatic push_word(input logic act, input logic [2:0] idx, input logic [31:0] dat,
                            input logic typed, input lmcs_pkg::pins_type pins);
      lmcs_pkg::pins_type got;
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'b0, dat, idx};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (act == lmcs_pkg::ACT_TICK) begin
         got = scan_tick();
         expected_pins.push_back(typed ? pins : got);
      end else if (idx < lmcs_pkg::IDX_W'(lmcs_pkg::FRAME_WORDS)) begin
         frame_words[idx] = dat;
      end
   endtask

   // mostly ticks, some frame writes, a few writes to indexes past the store
   task automatic random_words(input int count);
      int          done;
      logic [2:0]  idx;
      logic [31:0] dat;
      done = 0;
      while (done < count) begin
         case ($urandom_range(3, 0))
            0:       dat = '0;
            1:       dat = '1;
            default: dat = $urandom();
         endcase
         if ($urandom_range(99, 0) < 12) begin
            idx = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5))
                                             : 3'($urandom_range(4, 0));
            push_word(lmcs_pkg::ACT_WRITE, idx, dat, 1'b0, '0);
            if (idx < lmcs_pkg::IDX_W'(lmcs_pkg::FRAME_WORDS)) begin
               done++;
            end
         end else begin
            // ticks carry random filler in the unused fields
            push_word(lmcs_pkg::ACT_TICK, 3'($urandom_range(7, 0)), dat, 1'b0, '0);
            done++;
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic csr_access(input logic wr, input logic regsel, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {regsel, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_gap_reg(input logic regsel, input logic [lmcs_pkg::GAP_W-1:0] want);
      logic [31:0] rd;
      csr_access(1'b0, regsel, '0, rd);
      if (rd != {8'b0, want}) begin
         flag_error($sformatf("gap register %0d reads %0d, expected %0d", regsel, rd, want));
      end
   endtask

   // writes both gap registers (any upper bits are dropped) and reads them back
   task automatic set_gaps(input logic [31:0] col_val, input logic [31:0] frame_val);
      logic [31:0] rd;
      csr_access(1'b1, lmcs_pkg::REG_COLUMN_GAP, col_val, rd);
      column_gap = col_val[lmcs_pkg::GAP_W-1:0];
      csr_access(1'b1, lmcs_pkg::REG_FRAME_GAP, frame_val, rd);
      frame_gap = frame_val[lmcs_pkg::GAP_W-1:0];
      check_gap_reg(lmcs_pkg::REG_COLUMN_GAP, column_gap);
      check_gap_reg(lmcs_pkg::REG_FRAME_GAP, frame_gap);
   endtask

   // wait for every expected word, then let a trailing frame write settle
   task automatic drain();
      while (expected_pins.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off counted here on request
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (backpressure_due) begin
            backpressure_due = 1'b0;
            hold_left        = HOLD_OFF_TICKS;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // compare every accepted word with the oldest expectation, field by field
   always @(posedge clock) begin : compare_pins
      lmcs_pkg::pins_type want;
      lmcs_pkg::pins_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[2:0];
         if (expected_pins.size() == 0) begin
            flag_error($sformatf("unexpected response word %b", seen));
         end else begin
            want = expected_pins.pop_front();
            if (seen.shift_clock !== want.shift_clock || seen.shift_data !== want.shift_data ||
                seen.latch !== want.latch) begin
               flag_error($sformatf({"word %0d: expected clock %b data %b latch %b, ",
                                     "got clock %b data %b latch %b"}, result_count,
                                    want.shift_clock, want.shift_data, want.latch,
                                    seen.shift_clock, seen.shift_data, seen.latch));
            end
         end
         result_count++;
      end
   end

   initial begin
      // all block inputs known from time zero
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = lmcs_pkg::ACT_WRITE;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      fail_count       = 0;
      result_count     = 0;
      cycle_count      = 0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      backpressure_due = 1'b0;

      // predictor after reset
      foreach (frame_words[i]) frame_words[i] = '0;
      scan_col    = '0;
      scan_bit    = '0;
      scan_phase  = SCAN_LOW;
      gap_left    = '0;
      stream_bits = '0;
      column_gap  = 24'd1000;
      frame_gap   = 24'd10000;

      // opening words: column 0 with an empty frame streams 0xB2DA0, bits 0..7 typed in;
      // writes land mid-pass so they must not disturb it, indexes 5..7 are dropped
      opening_rows[0]  = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b000};
      opening_rows[1]  = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b001};
      opening_rows[2]  = '{lmcs_pkg::ACT_WRITE, 3'd4, 32'hFFFF_FFFF, 1'b0, 3'b000};
      opening_rows[3]  = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b000};
      opening_rows[4]  = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b001};
      opening_rows[5]  = '{lmcs_pkg::ACT_WRITE, 3'd7, 32'h1234_5678, 1'b0, 3'b000};
      opening_rows[6]  = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b000};
      opening_rows[7]  = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b001};
      opening_rows[8]  = '{lmcs_pkg::ACT_WRITE, 3'd5, 32'hFFFF_FFFF, 1'b0, 3'b000};
      opening_rows[9]  = '{lmcs_pkg::ACT_WRITE, 3'd0, 32'hAAAA_AAAA, 1'b0, 3'b000};
      opening_rows[10] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b000};
      opening_rows[11] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b001};
      opening_rows[12] = '{lmcs_pkg::ACT_WRITE, 3'd2, 32'h5555_5555, 1'b0, 3'b000};
      opening_rows[13] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b000};
      opening_rows[14] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b001};
      opening_rows[15] = '{lmcs_pkg::ACT_WRITE, 3'd1, 32'hFFFF_FFFF, 1'b0, 3'b000};
      opening_rows[16] = '{lmcs_pkg::ACT_WRITE, 3'd3, 32'h0,         1'b0, 3'b000};
      opening_rows[17] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b010};
      opening_rows[18] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b011};
      opening_rows[19] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b000};
      opening_rows[20] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b001};
      opening_rows[21] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b010};
      opening_rows[22] = '{lmcs_pkg::ACT_TICK,  3'd0, 32'h0,         1'b1, 3'b011};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values of the gap registers
      check_gap_reg(lmcs_pkg::REG_COLUMN_GAP, 24'd1000);
      check_gap_reg(lmcs_pkg::REG_FRAME_GAP, 24'd10000);

      foreach (opening_rows[i]) begin
         push_word(opening_rows[i].act, opening_rows[i].idx, opening_rows[i].dat,
                   opening_rows[i].typed, opening_rows[i].pins);
      end
      req_tvalid <= 1'b0;
      drain();

      // register extremes: all ones (upper byte dropped), then zero gaps for the run
      set_gaps(32'hFFFF_FFFF, {8'b0, GAP_MAX});
      set_gaps(32'd0, 32'd0);

      // zero gaps, sender idles lightly, receiver heavily
      send_idle_pct = 33;
      recv_idle_pct = 71;
      random_words(300);
      drain();

      // short gaps, the other way round
      set_gaps(32'd2, 32'd5);
      send_idle_pct = 71;
      recv_idle_pct = 33;
      random_words(350);
      drain();

      // no idling; a long receiver hold-off fills the output buffer and stalls input
      set_gaps(32'd1, 32'd40);
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      backpressure_due = 1'b1;
      random_words(350);
      drain();

      // random small gaps to close
      set_gaps($urandom_range(6, 0), $urandom_range(60, 0));
      random_words(350);
      drain();

      repeat (20) @(posedge clock);
      if (expected_pins.size() != 0) begin
         flag_error($sformatf("%0d response words never arrived", expected_pins.size()));
      end
      if (fail_count == 0) begin
         $display("led_matrix_column_scan_serializer_top verification clean");
      end else begin
         $display("led_matrix_column_scan_serializer_top verification failed");
      end
      $finish;
   end

endmodule
